>>> src/sad_pkg.sv
// shared constants for the signal activity detector
// field widths, register indexes and arithmetic widths; no dependencies
package sad_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int THR_W          = 20;
  localparam int LOUD_W         = 16;
  localparam int CFG_W          = 20;
  localparam int IDX_OUT_W      = 25;
  localparam int INDEX_BITS_DEF = 24;

  // operand width of the shared multiplier and width of the full measure
  localparam int MUL_W  = 19;
  localparam int AB_W   = 37;
  localparam int PROD_W = 56;
  localparam int THR50_W = 26;
  localparam int SUM_W  = 21;

  localparam int OUT_DATA_W = 80;

  localparam logic REG_NOISE_THRESHOLD = 1'b0;
  localparam logic REG_LOUD_LEVEL      = 1'b1;

  localparam logic [THR_W-1:0]  NOISE_THRESHOLD_RST = THR_W'(4096);
  localparam logic [LOUD_W-1:0] LOUD_LEVEL_RST      = LOUD_W'(16);

endpackage

>>> src/signal_activity_detector.sv
// signal activity detector: noise measure over a five-sample window with one
// shared 19x19 multiplier under a small sequencer; uses sad_pkg
// a beat passes ABC, M1, M2, M3 (three multiplier passes), SUM (product add)
// and FIN (threshold compare, result to the output register); a new sample is
// taken only in IDLE, so a result held back by out_tready delays the next beat
// reset: synchronous active-low rst_n clears record state, loads register defaults
module signal_activity_detector
  import sad_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // sample
  input  logic                  in_tlast,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // active, start_index, end_index,
                                            // loud_index, found, zero pad
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ABC  = 3'd1;
  localparam logic [2:0] ST_M1   = 3'd2;
  localparam logic [2:0] ST_M2   = 3'd3;
  localparam logic [2:0] ST_M3   = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
  localparam logic [IDX_OUT_W-1:0]  IDX_NONE = {IDX_OUT_W{1'b1}};

  logic [2:0]                 state_r;
  logic [THR_W-1:0]           noise_threshold_r;
  logic [LOUD_W-1:0]          loud_level_r;
  logic [THR50_W-1:0]         thr50_r;

  logic signed [SAMPLE_W-1:0] window_r [5];
  logic                       primed_r;
  logic [INDEX_BITS-1:0]      position_r;
  logic                       act_seen_r;
  logic                       loud_seen_r;
  logic [IDX_OUT_W-1:0]       first_active_r;
  logic [IDX_OUT_W-1:0]       last_active_r;
  logic [IDX_OUT_W-1:0]       first_loud_r;

  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic [MUL_W-1:0]           a_r, b_r, c_r;
  logic [AB_W-1:0]            ab_r;
  logic [2*MUL_W-1:0]         lo_r;
  logic [2*MUL_W-1:0]         hi_r;
  logic [PROD_W-1:0]          prod_r;

  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  // window arithmetic
  logic signed [SUM_W-1:0] older, s_all, a_val, b_val, c_val;
  logic [SUM_W-1:0]        a_mag, b_mag, c_mag;

  always_comb begin
    older = SUM_W'(window_r[0]) + SUM_W'(window_r[1]) + SUM_W'(window_r[2])
          + SUM_W'(window_r[3]);
    s_all = older + SUM_W'(window_r[4]);
    a_val = (SUM_W'(window_r[4]) <<< 1) + (SUM_W'(x_r) <<< 1) - older;
    b_val = (SUM_W'(window_r[4]) <<< 2) + SUM_W'(window_r[4]) - s_all;
    c_val = (SUM_W'(x_r) <<< 2) + SUM_W'(x_r) - s_all;
    a_mag = a_val[SUM_W-1] ? SUM_W'(-a_val) : SUM_W'(a_val);
    b_mag = b_val[SUM_W-1] ? SUM_W'(-b_val) : SUM_W'(b_val);
    c_mag = c_val[SUM_W-1] ? SUM_W'(-c_val) : SUM_W'(c_val);
  end

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;

  always_comb begin
    mul_a = a_r;
    mul_b = b_r;
    unique case (state_r)
      ST_M2: begin
        mul_a = ab_r[MUL_W-1:0];
        mul_b = c_r;
      end
      ST_M3: begin
        mul_a = MUL_W'(ab_r[AB_W-1:MUL_W]);
        mul_b = c_r;
      end
      default: begin
        mul_a = a_r;
        mul_b = b_r;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // final decision
  logic                  act;
  logic [SAMPLE_W:0]     x_mag;
  logic                  is_loud;
  logic [IDX_OUT_W-1:0]  k_idx;
  logic                  act_seen_nxt, loud_seen_nxt;
  logic [IDX_OUT_W-1:0]  first_active_nxt, last_active_nxt, first_loud_nxt;
  logic                  out_free;

  always_comb begin
    act      = prod_r > PROD_W'(thr50_r);
    x_mag    = x_r[SAMPLE_W-1] ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(x_r))
                               : (SAMPLE_W+1)'(x_r);
    is_loud  = x_mag >= {1'b0, loud_level_r};
    k_idx    = IDX_OUT_W'(position_r);
    act_seen_nxt     = act_seen_r | act;
    first_active_nxt = (act && !act_seen_r) ? k_idx : first_active_r;
    last_active_nxt  = act ? k_idx : last_active_r;
    loud_seen_nxt    = loud_seen_r | is_loud;
    first_loud_nxt   = (is_loud && !loud_seen_r) ? k_idx : first_loud_r;
    out_free = !out_valid_r || out_tready;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    thr50_r <= (THR50_W'(noise_threshold_r) << 5) + (THR50_W'(noise_threshold_r) << 4)
             + (THR50_W'(noise_threshold_r) << 1);
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      noise_threshold_r <= NOISE_THRESHOLD_RST;
      loud_level_r      <= LOUD_LEVEL_RST;
      primed_r          <= 1'b0;
      position_r        <= '0;
      act_seen_r        <= 1'b0;
      loud_seen_r       <= 1'b0;
      out_valid_r       <= 1'b0;
      for (int i = 0; i < 5; i++) window_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NOISE_THRESHOLD: noise_threshold_r <= cfg_data[THR_W-1:0];
          REG_LOUD_LEVEL:      loud_level_r      <= cfg_data[LOUD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready && (state_r != ST_FIN)) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r    <= in_tdata;
            last_r <= in_tlast;
            if (!primed_r) begin
              for (int i = 0; i < 5; i++) window_r[i] <= in_tdata;
              primed_r <= 1'b1;
            end
            state_r <= ST_ABC;
          end
        end
        ST_ABC: begin
          a_r     <= a_mag[MUL_W-1:0];
          b_r     <= b_mag[MUL_W-1:0];
          c_r     <= c_mag[MUL_W-1:0];
          state_r <= ST_M1;
        end
        ST_M1: begin
          ab_r    <= mul_p[AB_W-1:0];
          state_r <= ST_M2;
        end
        ST_M2: begin
          lo_r    <= mul_p;
          state_r <= ST_M3;
        end
        ST_M3: begin
          hi_r    <= mul_p;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          prod_r  <= PROD_W'(lo_r) + (PROD_W'(hi_r) << MUL_W);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000,
                            act_seen_nxt,
                            loud_seen_nxt ? first_loud_nxt : IDX_NONE,
                            act_seen_nxt ? last_active_nxt : IDX_NONE,
                            act_seen_nxt ? first_active_nxt : IDX_NONE,
                            act};
            if (last_r) begin
              for (int i = 0; i < 5; i++) window_r[i] <= '0;
              primed_r    <= 1'b0;
              position_r  <= '0;
              act_seen_r  <= 1'b0;
              loud_seen_r <= 1'b0;
            end else begin
              for (int i = 0; i < 4; i++) window_r[i] <= window_r[i+1];
              window_r[4]    <= x_r;
              act_seen_r     <= act_seen_nxt;
              loud_seen_r    <= loud_seen_nxt;
              first_active_r <= first_active_nxt;
              last_active_r  <= last_active_nxt;
              first_loud_r   <= first_loud_nxt;
              if (position_r != POS_MAX) position_r <= position_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
